@@ rtl/salru_pkg.sv @@
// shared types and constants for the set-associative lru tag lookup
// no dependencies; imported by every module of the block
`default_nettype none

package salru_pkg;

  localparam int MAX_WAYS     = 16;
  localparam int MAX_SETS     = 1024;
  localparam int ADDR_BITS    = 24;
  localparam int OFFSET_LIMIT = 10;

  localparam int SET_W   = $clog2(MAX_SETS);
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_W  = $clog2(MAX_WAYS + 1);
  localparam int TAG_W   = ADDR_BITS;
  localparam int OB_W    = 4;
  localparam int SB_W    = 4;
  localparam int SHIFT_W = OB_W + 1;

  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_SET_BITS    = 2'd1,
    REG_WAYS_IN_USE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef entry_t [MAX_WAYS-1:0] row_t;

  // effective geometry after clamping
  typedef struct packed {
    logic [OB_W-1:0]   ob;
    logic [SB_W-1:0]   sb;
    logic [WAYS_W-1:0] ways;
  } geom_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/salru_cfg.sv @@
// configuration registers and geometry clamping
// depends on salru_pkg
`default_nettype none

module salru_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic [salru_pkg::REG_IDX_W-1:0]     cfg_index,
  input  wire logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
  output salru_pkg::geom_t                         geom
);
  import salru_pkg::*;

  logic [OB_W-1:0]   offset_bits;
  logic [SB_W-1:0]   set_bits;
  logic [WAYS_W-1:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OB_W'(2);
      set_bits    <= SB_W'(4);
      ways_in_use <= WAYS_W'(4);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data[OB_W-1:0];
        REG_SET_BITS:    set_bits    <= cfg_data[SB_W-1:0];
        REG_WAYS_IN_USE: ways_in_use <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.ob   = (offset_bits > OB_W'(OFFSET_LIMIT)) ? OB_W'(OFFSET_LIMIT) : offset_bits;
    geom.sb   = (set_bits > SB_W'(SET_W)) ? SB_W'(SET_W) : set_bits;
    if (ways_in_use == '0) begin
      geom.ways = WAYS_W'(1);
    end else if (ways_in_use > WAYS_W'(MAX_WAYS)) begin
      geom.ways = WAYS_W'(MAX_WAYS);
    end else begin
      geom.ways = ways_in_use;
    end
  end

endmodule

`default_nettype wire

@@ rtl/salru_ctrl.sv @@
// sequencer: clearing pass, accept, then lookup and write-back
// depends on salru_pkg
`default_nettype none

module salru_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire salru_pkg::status_t   status,
  output salru_pkg::cmd_t           cmd,
  output logic                      in_ready
);
  import salru_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // hold the looked-up row until the result register can take it
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/salru_dp.sv @@
// datapath: address split, tag row memory, way search, lru reorder, result register
// depends on salru_pkg
`default_nettype none

module salru_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire salru_pkg::geom_t                 geom,
  input  wire salru_pkg::cmd_t                  cmd,
  output salru_pkg::status_t                    status,
  input  wire logic                             kind,
  input  wire logic [salru_pkg::ADDR_BITS-1:0]  address,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  hit,
  output logic [salru_pkg::SET_W-1:0]           set_index,
  output logic [salru_pkg::TAG_W-1:0]           tag_value
);
  import salru_pkg::*;

  row_t mem [MAX_SETS];
  row_t rdata;

  logic [SET_W-1:0] clr_cnt;
  logic             kind_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  logic [ADDR_BITS-1:0] shifted;
  logic [SET_W-1:0]     set_mask;
  logic [SET_W-1:0]     set_in;
  logic [SHIFT_W-1:0]   tag_shift;
  logic [TAG_W-1:0]     tag_in;

  logic [MAX_WAYS-1:0] match;
  logic                found;
  logic [WAY_W-1:0]    idx;
  logic                we;
  row_t                new_row;
  logic [SET_W-1:0]    waddr;
  row_t                wdata;

  // address split for the incoming transaction
  always_comb begin
    shifted   = address >> geom.ob;
    set_mask  = ~({SET_W{1'b1}} << geom.sb);
    set_in    = shifted[SET_W-1:0] & set_mask;
    tag_shift = SHIFT_W'(geom.ob) + SHIFT_W'(geom.sb);
    tag_in    = TAG_W'(address >> tag_shift);
  end

  // search ways in most-recent-first order
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = (WAYS_W'(w) < geom.ways) && rdata[w].valid && (rdata[w].tag == tag_q);
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        found = 1'b1;
        idx   = WAY_W'(w);
      end
    end
  end

  // hit: shift ways up to the match; load miss: shift every way in use
  always_comb begin
    new_row          = rdata;
    new_row[0].valid = 1'b1;
    new_row[0].tag   = tag_q;
    for (int j = 1; j < MAX_WAYS; j++) begin
      if (found ? (WAY_W'(j) <= idx) : (WAYS_W'(j) < geom.ways)) begin
        new_row[j] = rdata[j-1];
      end
    end
  end

  assign we    = cmd.clear || (cmd.commit && (found || !kind_q));
  assign waddr = cmd.clear ? clr_cnt : set_q;
  assign wdata = cmd.clear ? row_t'('0) : new_row;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.accept) begin
      rdata <= mem[set_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= kind;
      set_q  <= set_in;
      tag_q  <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit       <= found;
      set_index <= set_q;
      tag_value <= tag_q;
    end
  end

  assign status.clear_last = (clr_cnt == SET_W'(MAX_SETS - 1));
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ rtl/set_assoc_lru_tag_lookup_top.sv @@
// Set-associative tag lookup with lru order and write-no-allocate.
// Input channel in_valid/in_ready carries kind (0 load, 1 store) and a byte address.
// Output channel out_valid/out_ready returns hit, set_index and tag_value, one
// transaction per access, in order.
// Configuration channel cfg_valid/cfg_ready writes offset_bits (index 0),
// set_bits (index 1) and ways_in_use (index 2); it is always ready. Write it
// only while no access is in flight.
// On acceptance the set's row is read from the tag memory; in ST_CHECK the ways are
// searched and the reordered row is written back. The single-port read-modify-write
// of that row means a new access is not accepted until the last one is written back,
// and an access to the same set right after sees the updated order.
// The result is loaded into the output register at that write-back.
// After reset the tag memory is cleared one set per cycle, all 1024 sets,
// during which in_ready is low; configuration writes are still taken.
// A result waits in an output register; while it is stalled the next access
// can be accepted and read, but it is not committed until the register frees.
// depends on salru_pkg, salru_cfg, salru_ctrl, salru_dp
`default_nettype none

module set_assoc_lru_tag_lookup_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               kind,
  input  wire logic [salru_pkg::ADDR_BITS-1:0]    address,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    hit,
  output logic [salru_pkg::SET_W-1:0]             set_index,
  output logic [salru_pkg::TAG_W-1:0]             tag_value,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [salru_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [salru_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import salru_pkg::*;

  geom_t   geom;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  salru_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  salru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  salru_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .cmd       (cmd),
    .status    (status),
    .kind      (kind),
    .address   (address),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .set_index (set_index),
    .tag_value (tag_value)
  );

  // one access at a time: no second transaction right after an accept
  a_single_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a result cannot appear in the cycle right after acceptance
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result produced before lookup");

  // clearing pass keeps the input closed after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready during clearing pass");

endmodule

`default_nettype wire
